>>> hdl/mes_pkg.sv
// Shared types and constants for the multichannel EMA glitch scanner.
`default_nettype none

package mes_pkg;

    // Channel count and the width of the channel number.
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = 4;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MS    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA_Q8  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_LIMIT = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK  = 8'd4;

    // Register reset values.
    localparam logic [15:0] RST_MIN_GAP       = 16'd10;
    localparam logic [8:0]  RST_EMA_ALPHA     = 9'd64;
    localparam logic [11:0] RST_OUTLIER_LIMIT = 12'd200;
    localparam logic [15:0] RST_CHANNEL_MASK  = 16'hFFFF;

    // Alpha of 1.0 in Q1.8.
    localparam logic [8:0] ALPHA_ONE = 9'd256;

    // Time stamp width.
    localparam int TIME_W = 32;

    // What happened to the visited channel on one tick.
    typedef enum logic [2:0] {
        ACT_STOPPED  = 3'd0,
        ACT_NOT_DUE  = 3'd1,
        ACT_SKIPPED  = 3'd2,
        ACT_ACCEPTED = 3'd3,
        ACT_REJECTED = 3'd4
    } t_action;

    // Configuration register contents.
    typedef struct packed {
        logic        scan_enable;
        logic [15:0] min_gap_ms;
        logic [8:0]  ema_alpha_q8;
        logic [11:0] outlier_limit;
        logic [15:0] channel_enable_mask;
    } t_cfg;

    // Decision for the channel entry on one tick.
    typedef struct packed {
        t_action action;
        logic    advance;
        logic    write_entry;
        logic    clear_valid;
    } t_upd_ctl;

endpackage : mes_pkg

`default_nettype wire

>>> hdl/mes_ifs.sv
// Handshake interfaces for the sample input, result output and configuration channels.
`default_nettype none

interface mes_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                        valid;
    logic                        ready;
    logic [mes_pkg::TIME_W-1:0]  now_ms;
    logic [SAMPLE_BITS-1:0]      sample;

    modport source (output valid, output now_ms, output sample, input ready);
    modport sink   (input valid, input now_ms, input sample, output ready);
endinterface : mes_in_if

interface mes_out_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [3:0]               channel;
    logic [2:0]               action;
    logic [SAMPLE_BITS-1:0]   raw_level;
    logic [SAMPLE_BITS+7:0]   ema_level;
    logic                     reading_valid;

    modport source (output valid, output channel, output action, output raw_level,
                    output ema_level, output reading_valid, input ready);
    modport sink   (input valid, input channel, input action, input raw_level,
                    input ema_level, input reading_valid, output ready);
endinterface : mes_out_if

interface mes_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mes_pkg::CFG_IDX_W-1:0]   index;
    logic [mes_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : mes_cfg_if

`default_nettype wire

>>> hdl/mes_cfg_regs.sv
// Configuration register file of the scanner.
`default_nettype none

module mes_cfg_regs (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mes_cfg_if.sink       i_cfg,
    output mes_pkg::t_cfg o_cfg,
    output logic          o_ptr_clear
);
    import mes_pkg::*;

    t_cfg r_cfg;
    logic wr;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid;

    // Turning scanning on restarts the scan at channel zero.
    assign o_ptr_clear = wr && (i_cfg.index == CFG_SCAN_ENABLE) && i_cfg.data[0]
                         && !r_cfg.scan_enable;

    // Register writes by index; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_enable         <= 1'b0;
            r_cfg.min_gap_ms          <= RST_MIN_GAP;
            r_cfg.ema_alpha_q8        <= RST_EMA_ALPHA;
            r_cfg.outlier_limit       <= RST_OUTLIER_LIMIT;
            r_cfg.channel_enable_mask <= RST_CHANNEL_MASK;
        end else if (wr) begin
            unique case (i_cfg.index)
                CFG_SCAN_ENABLE:   r_cfg.scan_enable         <= i_cfg.data[0];
                CFG_MIN_GAP_MS:    r_cfg.min_gap_ms          <= i_cfg.data;
                CFG_EMA_ALPHA_Q8:  r_cfg.ema_alpha_q8        <= i_cfg.data[8:0];
                CFG_OUTLIER_LIMIT: r_cfg.outlier_limit       <= i_cfg.data[11:0];
                CFG_CHANNEL_MASK:  r_cfg.channel_enable_mask <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule : mes_cfg_regs

`default_nettype wire

>>> hdl/mes_update.sv
// Per-tick decision and EMA arithmetic for the visited channel.
`default_nettype none

module mes_update #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire mes_pkg::t_cfg      i_cfg,
    input  wire logic [3:0]         i_chan,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SAMPLE_BITS-1:0] i_raw,
    input  wire logic [SAMPLE_BITS+7:0] i_ema,
    input  wire logic [31:0]        i_last_time,
    input  wire logic               i_valid_flag,
    output mes_pkg::t_upd_ctl       o_ctl,
    output logic [SAMPLE_BITS+7:0]  o_new_ema,
    output logic [SAMPLE_BITS-1:0]  o_raw_after,
    output logic [SAMPLE_BITS+7:0]  o_ema_after,
    output logic                    o_valid_after,
    input  wire logic [31:0]        i_now_ms
);
    import mes_pkg::*;

    localparam int EMA_W = SAMPLE_BITS + 8;
    localparam int CMP_W = (EMA_W > 20) ? EMA_W : 20;
    localparam int ACC_W = SAMPLE_BITS + 18;

    logic [31:0]      elapsed;
    logic             due;
    logic [EMA_W-1:0] sq;
    logic [EMA_W-1:0] deviation;
    logic [CMP_W-1:0] thr_q8;
    logic             glitch;
    logic [8:0]       alpha;
    logic [8:0]       alpha_inv;
    logic [ACC_W-1:0] acc;
    logic [EMA_W-1:0] ema_blend;

    // Due test with modulo-2^32 time difference.
    assign elapsed = i_now_ms - i_last_time;
    assign due     = elapsed >= {16'd0, i_cfg.min_gap_ms};

    // Distance of the sample from the EMA, both in Q12.8.
    assign sq        = {i_sample, 8'd0};
    assign deviation = (sq > i_ema) ? (sq - i_ema) : (i_ema - sq);
    assign thr_q8    = CMP_W'({i_cfg.outlier_limit, 8'd0});
    assign glitch    = (i_ema != '0) && (CMP_W'(deviation) > thr_q8);

    // EMA blend, alpha saturated at 1.0 and the result rounded half up.
    assign alpha     = (i_cfg.ema_alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : i_cfg.ema_alpha_q8;
    assign alpha_inv = ALPHA_ONE - alpha;
    assign acc = (ACC_W'(alpha) * ACC_W'(i_sample) << 8)
               + ACC_W'(alpha_inv) * ACC_W'(i_ema)
               + ACC_W'(128);
    assign ema_blend = acc[EMA_W+7:8];

    // A zero EMA marks the first reading, which is taken as it is.
    assign o_new_ema = (i_ema == '0) ? sq : ema_blend;

    // Decide what this tick does with the channel.
    always_comb begin
        o_ctl = '{action: ACT_STOPPED, advance: 1'b0, write_entry: 1'b0,
                  clear_valid: 1'b0};
        if (!i_cfg.scan_enable) begin
            o_ctl.action = ACT_STOPPED;
        end else if (!due) begin
            o_ctl.action = ACT_NOT_DUE;
        end else if (!i_cfg.channel_enable_mask[i_chan]) begin
            o_ctl.action  = ACT_SKIPPED;
            o_ctl.advance = 1'b1;
        end else if (glitch) begin
            o_ctl.action      = ACT_REJECTED;
            o_ctl.advance     = 1'b1;
            o_ctl.clear_valid = 1'b1;
        end else begin
            o_ctl.action      = ACT_ACCEPTED;
            o_ctl.advance     = 1'b1;
            o_ctl.write_entry = 1'b1;
        end
    end

    // Channel contents as they stand after this tick.
    assign o_raw_after   = o_ctl.write_entry ? i_sample : i_raw;
    assign o_ema_after   = o_ctl.write_entry ? o_new_ema : i_ema;
    assign o_valid_after = o_ctl.write_entry ? 1'b1
                         : (o_ctl.clear_valid ? 1'b0 : i_valid_flag);

endmodule : mes_update

`default_nettype wire

>>> hdl/mes_chan_store.sv
// Per-channel state: raw value, EMA, last sample time, valid flag and the scan pointer.
`default_nettype none

module mes_chan_store #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_ptr_clear,
    input  wire mes_pkg::t_upd_ctl      i_ctl,
    input  wire logic [31:0]            i_now_ms,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SAMPLE_BITS+7:0] i_new_ema,
    output logic [3:0]                  o_chan,
    output logic [SAMPLE_BITS-1:0]      o_raw,
    output logic [SAMPLE_BITS+7:0]      o_ema,
    output logic [31:0]                 o_last_time,
    output logic                        o_valid_flag
);
    import mes_pkg::*;

    logic [CHAN_W-1:0]      r_ptr;
    logic [SAMPLE_BITS-1:0] r_raw   [NUM_CHANNELS];
    logic [SAMPLE_BITS+7:0] r_ema   [NUM_CHANNELS];
    logic [31:0]            r_time  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_valid;

    // Scan pointer: wraps after the last channel, restarts when scanning turns on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_ptr_clear) begin
            r_ptr <= '0;
        end else if (i_step && i_ctl.advance) begin
            r_ptr <= (r_ptr == CHAN_W'(NUM_CHANNELS - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    // Channel entries, all zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_raw[i]  <= '0;
                r_ema[i]  <= '0;
                r_time[i] <= '0;
            end
            r_valid <= '0;
        end else if (i_step) begin
            if (i_ctl.write_entry) begin
                r_raw[r_ptr]   <= i_sample;
                r_ema[r_ptr]   <= i_new_ema;
                r_time[r_ptr]  <= i_now_ms;
                r_valid[r_ptr] <= 1'b1;
            end else if (i_ctl.clear_valid) begin
                r_valid[r_ptr] <= 1'b0;
            end
        end
    end

    // Entry of the channel the pointer selects.
    assign o_chan       = r_ptr;
    assign o_raw        = r_raw[r_ptr];
    assign o_ema        = r_ema[r_ptr];
    assign o_last_time  = r_time[r_ptr];
    assign o_valid_flag = r_valid[r_ptr];

endmodule : mes_chan_store

`default_nettype wire

>>> hdl/multichannel_ema_glitch_scanner.sv
// An accepted item waits in the input register and moves on to the output register
// when the latter is free or being emptied. Throughput: one item per cycle unless the
// output stalls; the channel entry is read, updated and written back as the item
// moves on, and input ready drops only while both registers are full.
// Reset (synchronous, active low) clears the handshake state, the scan pointer, all
// channel entries and loads the configuration registers with their defaults.
`default_nettype none

module multichannel_ema_glitch_scanner #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mes_in_if.sink    i_in,
    mes_out_if.source o_out,
    mes_cfg_if.sink   i_cfg
);
    import mes_pkg::*;

    t_cfg     cfg;
    logic     ptr_clear;
    t_upd_ctl ctl;
    logic     step;

    logic                   r_in_vld;
    logic [31:0]            r_now_ms;
    logic [SAMPLE_BITS-1:0] r_sample;

    logic                   r_out_vld;
    logic [3:0]             r_chan;
    t_action                r_action;
    logic [SAMPLE_BITS-1:0] r_raw;
    logic [SAMPLE_BITS+7:0] r_ema;
    logic                   r_valid_flag;

    logic [3:0]             chan;
    logic [SAMPLE_BITS-1:0] st_raw;
    logic [SAMPLE_BITS+7:0] st_ema;
    logic [31:0]            st_time;
    logic                   st_valid;
    logic [SAMPLE_BITS+7:0] new_ema;
    logic [SAMPLE_BITS-1:0] raw_after;
    logic [SAMPLE_BITS+7:0] ema_after;
    logic                   valid_after;

    // Configuration registers.
    mes_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_cfg       (cfg),
        .o_ptr_clear (ptr_clear)
    );

    // The held item moves on whenever the output register is free or being emptied.
    assign step       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_now_ms <= i_in.now_ms;
            r_sample <= i_in.sample;
        end
    end

    // Channel state and scan pointer.
    mes_chan_store #(.SAMPLE_BITS(SAMPLE_BITS)) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_ptr_clear  (ptr_clear),
        .i_ctl        (ctl),
        .i_now_ms     (r_now_ms),
        .i_sample     (r_sample),
        .i_new_ema    (new_ema),
        .o_chan       (chan),
        .o_raw        (st_raw),
        .o_ema        (st_ema),
        .o_last_time  (st_time),
        .o_valid_flag (st_valid)
    );

    // Decision and EMA update for the visited channel.
    mes_update #(.SAMPLE_BITS(SAMPLE_BITS)) u_update (
        .i_cfg         (cfg),
        .i_chan        (chan),
        .i_sample      (r_sample),
        .i_raw         (st_raw),
        .i_ema         (st_ema),
        .i_last_time   (st_time),
        .i_valid_flag  (st_valid),
        .o_ctl         (ctl),
        .o_new_ema     (new_ema),
        .o_raw_after   (raw_after),
        .o_ema_after   (ema_after),
        .o_valid_after (valid_after),
        .i_now_ms      (r_now_ms)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_chan       <= chan;
            r_action     <= ctl.action;
            r_raw        <= raw_after;
            r_ema        <= ema_after;
            r_valid_flag <= valid_after;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.channel       = r_chan;
    assign o_out.action        = r_action;
    assign o_out.raw_level     = r_raw;
    assign o_out.ema_level     = r_ema;
    assign o_out.reading_valid = r_valid_flag;

endmodule : multichannel_ema_glitch_scanner

`default_nettype wire

>>> tb/sv/multichannel_ema_glitch_scanner_tb.sv
// Testbench for the multichannel EMA glitch scanner: random ticks checked against a scan predictor.
module multichannel_ema_glitch_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mes_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER = 30;

    // Register indexes that the block has no register for.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP    = 8'hFF;

    // One tick offered to the scanner.
    typedef struct {
        logic [31:0] now;
        logic [11:0] sample;
    } t_scan_item;

    // What the scanner reports for one tick.
    typedef struct {
        logic [3:0]  channel;
        t_action     action;
        logic [11:0] raw;
        logic [19:0] filtered;
        logic        reading_valid;
    } t_scan_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mes_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
    mes_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();
    mes_cfg_if                              cfg_if ();

    multichannel_ema_glitch_scanner #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_if),
        .o_out   (result_if),
        .i_cfg   (cfg_if)
    );

    // Ticks waiting to be offered and results waiting to be seen.
    t_scan_item   pending_items[$];
    t_scan_result expected_results[$];
    int           error_count = 0;
    int           cycle_count = 0;

    // Predictor state: the scan pointer, the channel entries and the registers.
    logic [3:0]  scan_ptr;
    logic [11:0] raw_mem   [NUM_CHANNELS];
    logic [19:0] ema_mem   [NUM_CHANNELS];
    logic [31:0] stamp_mem [NUM_CHANNELS];
    logic        valid_mem [NUM_CHANNELS];
    t_cfg        reg_model;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out one tick of the scanner and update the predictor state.
    function automatic t_scan_result scan_tick(input logic [31:0] now, input logic [11:0] s);
        t_scan_result r;
        logic [3:0]   ch;
        logic [31:0]  elapsed;
        logic [31:0]  sq;
        logic [31:0]  deviation;
        logic [19:0]  cur;
        logic [8:0]   a;
        logic [39:0]  a_w;
        logic [39:0]  acc;
        logic         glitch;
        logic         step;
        ch      = scan_ptr;
        step    = 1'b0;
        elapsed = now - stamp_mem[ch];
        if (!reg_model.scan_enable) begin
            r.action = ACT_STOPPED;
        end else if (elapsed < {16'd0, reg_model.min_gap_ms}) begin
            r.action = ACT_NOT_DUE;
        end else if (!reg_model.channel_enable_mask[ch]) begin
            r.action = ACT_SKIPPED;
            step     = 1'b1;
        end else begin
            cur    = ema_mem[ch];
            sq     = {12'd0, s, 8'd0};
            glitch = 1'b0;
            // A zero EMA means the channel has no reading yet, so no outlier test.
            if (cur != 20'd0) begin
                deviation = (sq > {12'd0, cur}) ? sq - {12'd0, cur} : {12'd0, cur} - sq;
                glitch    = deviation > {12'd0, reg_model.outlier_limit, 8'd0};
            end
            if (glitch) begin
                valid_mem[ch] = 1'b0;
                r.action      = ACT_REJECTED;
            end else begin
                raw_mem[ch] = s;
                if (cur == 20'd0) begin
                    ema_mem[ch] = sq[19:0];
                end else begin
                    // Alpha above one saturates; the blend rounds half up.
                    a   = (reg_model.ema_alpha_q8 > ALPHA_ONE) ? ALPHA_ONE
                                                               : reg_model.ema_alpha_q8;
                    a_w = {31'd0, a};
                    acc = a_w * {8'd0, sq} + ({31'd0, ALPHA_ONE} - a_w) * {20'd0, cur}
                          + 40'd128;
                    ema_mem[ch] = acc[27:8];
                end
                valid_mem[ch] = 1'b1;
                stamp_mem[ch] = now;
                r.action      = ACT_ACCEPTED;
            end
            step = 1'b1;
        end
        r.channel       = ch;
        r.raw           = raw_mem[ch];
        r.filtered      = ema_mem[ch];
        r.reading_valid = valid_mem[ch];
        if (step)
            scan_ptr = ch + 4'd1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 40)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
        error_count++;
    endtask

    task automatic push_item(input logic [31:0] now, input logic [11:0] s);
        t_scan_item it;
        it.now    = now;
        it.sample = s;
        pending_items.push_back(it);
    endtask

    // Wait until every tick has been taken and every result has come back.
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register and mirror the write in the predictor.
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_SCAN_ENABLE: begin
                // Turning scanning on sends the pointer back to channel 0.
                if (value[0] && !reg_model.scan_enable)
                    scan_ptr = 4'd0;
                reg_model.scan_enable = value[0];
            end
            CFG_MIN_GAP_MS:    reg_model.min_gap_ms          = value;
            CFG_EMA_ALPHA_Q8:  reg_model.ema_alpha_q8        = value[8:0];
            CFG_OUTLIER_LIMIT: reg_model.outlier_limit       = value[11:0];
            CFG_CHANNEL_MASK:  reg_model.channel_enable_mask = value;
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    // Sender: offers queued ticks in bursts with random gaps between them.
    int send_burst_left = 1;
    int send_gap_left = 0;

    always @(posedge i_clk) begin : drive_ticks
        logic offered;
        if (!i_rst_n) begin
            sample_if.valid  <= 1'b0;
            sample_if.now_ms <= '0;
            sample_if.sample <= '0;
            send_gap_left    <= 0;
        end else begin
            offered = sample_if.valid;
            if (sample_if.valid && sample_if.ready) begin
                expected_results.push_back(scan_tick(sample_if.now_ms, sample_if.sample));
                void'(pending_items.pop_front());
                offered = 1'b0;
            end
            // A tick on offer stays until taken; otherwise start the next one or idle.
            if (!offered) begin
                if (send_gap_left != 0) begin
                    sample_if.valid <= 1'b0;
                    send_gap_left   <= send_gap_left - 1;
                end else if (pending_items.size() != 0) begin
                    sample_if.valid  <= 1'b1;
                    sample_if.now_ms <= pending_items[0].now;
                    sample_if.sample <= pending_items[0].sample;
                    if (send_burst_left <= 1) begin
                        send_burst_left <= $urandom_range(1, 16);
                        send_gap_left   <= $urandom_range(0, 12);
                    end else begin
                        send_burst_left <= send_burst_left - 1;
                    end
                end else begin
                    sample_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls in changing patterns, and once holds off for a long stretch.
    int results_taken = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready)
                results_taken <= results_taken + 1;
            if (hold_left != 0) begin
                result_if.ready <= 1'b0;
                hold_left       <= hold_left - 1;
            end else if (!long_hold_done && results_taken == LONG_HOLD_AFTER) begin
                result_if.ready <= 1'b0;
                hold_left       <= LONG_HOLD_CYCLES;
                long_hold_done  <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left  <= $urandom_range(8, 64);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (stall_mode)
                    0: result_if.ready <= 1'b1;
                    1: result_if.ready <= 1'($urandom_range(0, 1));
                    2: result_if.ready <= ($urandom_range(0, 3) == 0);
                    default: result_if.ready <= mode_left[0];
                endcase
            end
        end
    end

    // Monitor: every result taken is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_scan_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected, channel",
                                32'(result_if.channel), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (result_if.channel !== want.channel)
                    report_mismatch("channel", 32'(result_if.channel), 32'(want.channel));
                if (result_if.action !== want.action)
                    report_mismatch("action", 32'(result_if.action), 32'(want.action));
                if (result_if.raw_level !== want.raw)
                    report_mismatch("raw level", 32'(result_if.raw_level), 32'(want.raw));
                if (result_if.ema_level !== want.filtered)
                    report_mismatch("EMA level", 32'(result_if.ema_level),
                                    32'(want.filtered));
                if (result_if.reading_valid !== want.reading_valid)
                    report_mismatch("reading_valid", 32'(result_if.reading_valid),
                                    32'(want.reading_valid));
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] interval;
        logic [8:0]  alpha;
        logic [11:0] thr;
        logic [15:0] mask;
        logic [15:0] rnd;
        logic [31:0] tick_time;
        int          base;
        int          s_val;
        int          pick;
        int          count;

        // Known values on every input, and the predictor at its reset state.
        i_rst_n          = 1'b0;
        sample_if.valid  = 1'b0;
        sample_if.now_ms = '0;
        sample_if.sample = '0;
        result_if.ready  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        reg_model.scan_enable         = 1'b0;
        reg_model.min_gap_ms          = RST_MIN_GAP;
        reg_model.ema_alpha_q8        = RST_EMA_ALPHA;
        reg_model.outlier_limit       = RST_OUTLIER_LIMIT;
        reg_model.channel_enable_mask = RST_CHANNEL_MASK;
        scan_ptr = 4'd0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            raw_mem[i]   = '0;
            ema_mem[i]   = '0;
            stamp_mem[i] = '0;
            valid_mem[i] = 1'b0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset scanning is stopped: the channel 0 entry is reported as is.
        push_item(32'h0000_0000, 12'h000);
        push_item(32'hFFFF_FFFF, 12'hFFF);
        wait_idle();

        // Always due, alpha of one, zero threshold; unknown indexes must change nothing.
        write_reg(CFG_MIN_GAP_MS, 16'd0);
        write_reg(CFG_EMA_ALPHA_Q8, {7'd0, ALPHA_ONE});
        write_reg(CFG_OUTLIER_LIMIT, 16'd0);
        write_reg(CFG_CHANNEL_MASK, 16'hFFFF);
        write_reg(CFG_INDEX_UNUSED, 16'hFFFF);
        write_reg(CFG_INDEX_TOP, 16'h0000);
        write_reg(CFG_SCAN_ENABLE, 16'd1);
        // First readings, a zero sample among them.
        push_item(32'd10, 12'hFFF);
        push_item(32'd11, 12'h000);
        push_item(32'd12, 12'h001);
        push_item(32'd13, 12'h800);
        wait_idle();

        // Stop and restart: the pointer goes back to channel 0.
        write_reg(CFG_SCAN_ENABLE, 16'd0);
        write_reg(CFG_SCAN_ENABLE, 16'd1);
        // Exact match passes a zero threshold, a zero EMA is a first reading again,
        // and a far sample on a live channel is rejected.
        push_item(32'd20, 12'hFFF);
        push_item(32'd21, 12'hFFF);
        push_item(32'd22, 12'hFFF);
        push_item(32'd23, 12'h800);
        wait_idle();

        // Enabling again while enabled keeps the pointer; alpha saturates; channel 4 off.
        write_reg(CFG_SCAN_ENABLE, 16'hFFFF);
        write_reg(CFG_MIN_GAP_MS, 16'hFFFF);
        write_reg(CFG_EMA_ALPHA_Q8, 16'hFFFF);
        write_reg(CFG_OUTLIER_LIMIT, 16'h0FFF);
        write_reg(CFG_CHANNEL_MASK, 16'hFFEF);
        push_item(32'hFFFF_FFF0, 12'd100);
        push_item(32'hFFFF_FFF0, 12'd4000);
        push_item(32'hFFFF_FFF1, 12'd7);
        // Channel 7 is not due until the full interval has passed.
        push_item(32'd5, 12'd300);
        push_item(32'd65534, 12'd300);
        push_item(32'd65535, 12'd300);
        wait_idle();

        // Short interval across the time wrap, with upper data bits set.
        write_reg(CFG_MIN_GAP_MS, 16'd16);
        write_reg(CFG_OUTLIER_LIMIT, 16'hF032);
        write_reg(CFG_EMA_ALPHA_Q8, 16'hFE40);
        push_item(32'hFFFF_FFF8, 12'd1000);
        push_item(32'hFFFF_FFF8, 12'd2000);
        push_item(32'd8, 12'd3000);
        push_item(32'd16, 12'd3000);
        push_item(32'd17, 12'd2500);

        // Random phases, each with its own register setting.
        tick_time = 32'd100;
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            if (ph == 0)
                interval = 16'd0;
            else if (ph == 3)
                interval = 16'hFFFF;
            else
                interval = 16'($urandom_range(1, 24));
            if (ph == 0)
                alpha = 9'd0;
            else if (ph == 1)
                alpha = ALPHA_ONE;
            else if (ph == 2)
                alpha = 9'h1FF;
            else
                alpha = 9'($urandom_range(0, 511));
            case ($urandom_range(0, 3))
                0: thr = 12'd0;
                1: thr = 12'hFFF;
                2: thr = 12'($urandom_range(0, 60));
                default: thr = 12'($urandom_range(0, 4095));
            endcase
            if (ph == 1)
                mask = 16'h0000;
            else if (ph == 5)
                mask = 16'hFFFF;
            else
                mask = 16'($urandom);
            rnd = 16'($urandom);
            write_reg(CFG_MIN_GAP_MS, interval);
            write_reg(CFG_EMA_ALPHA_Q8, {rnd[15:9], alpha});
            write_reg(CFG_OUTLIER_LIMIT, {rnd[3:0], thr});
            write_reg(CFG_CHANNEL_MASK, mask);
            if (ph == 4) begin
                write_reg(CFG_SCAN_ENABLE, {rnd[15:1], 1'b0});
            end else begin
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_SCAN_ENABLE, 16'd0);
                write_reg(CFG_SCAN_ENABLE, {rnd[14:0], 1'b1});
            end

            count = (ph == 1 || ph == 4) ? 25 : 60;
            pick  = int'($urandom_range(0, 2));
            if (pick == 0)
                tick_time = 32'hFFFF_FFFF - $urandom_range(0, 300);
            else if (pick == 1)
                tick_time = $urandom;
            base = int'($urandom_range(0, 4095));

            for (int k = 0; k < count; k++) begin
                if (interval > 16'd1000)
                    tick_time = tick_time + $urandom_range(0, 12000);
                else
                    tick_time = tick_time + $urandom_range(0, 3);
                // Mostly samples close to a slowly drifting level, some outliers.
                pick = int'($urandom_range(0, 99));
                if (pick < 65) begin
                    s_val = base + int'($urandom_range(0, 40)) - 20;
                end else if (pick < 78) begin
                    s_val = int'($urandom_range(0, 4095));
                end else if (pick < 84) begin
                    s_val = 0;
                end else if (pick < 90) begin
                    s_val = 4095;
                end else begin
                    base = base + int'($urandom_range(0, 300)) - 150;
                    if (base < 0)
                        base = 0;
                    if (base > 4095)
                        base = 4095;
                    s_val = base;
                end
                if (s_val < 0)
                    s_val = 0;
                if (s_val > 4095)
                    s_val = 4095;
                push_item(tick_time, s_val[11:0]);
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule : multichannel_ema_glitch_scanner_tb

>>> filelist.f
hdl/mes_pkg.sv
hdl/mes_ifs.sv
hdl/mes_cfg_regs.sv
hdl/mes_update.sv
hdl/mes_chan_store.sv
hdl/multichannel_ema_glitch_scanner.sv
tb/sv/multichannel_ema_glitch_scanner_tb.sv
